### rtl/grti_pkg.sv
// Package for the gyro rotation table interpolator: types, constants, opcodes.
// No dependencies; imported by every module in rtl.
`timescale 1ns / 1ps
package grti_pkg;
  localparam int TABLE_DEPTH = 2048;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        sample_time;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] angle_x;
    logic signed [31:0] angle_y;
    logic signed [31:0] angle_z;
    logic               table_ready;
    logic               overflowed;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        t;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RDPREV, S_WAITPREV, S_MUL, S_ADD, S_WRITE,
    S_SCAN, S_SCANCHK, S_RDB, S_WAITB, S_MULQ, S_DIV, S_FIN, S_EMIT
  } state_t;
endpackage

### rtl/grti_ram.sv
// Single-port synchronous table memory with registered read.
// Depends on grti_pkg for the entry type and address width.
`timescale 1ns / 1ps
module grti_ram
  import grti_pkg::*;
(
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  entry_t        wdata,
  output entry_t        rdata
);
  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### rtl/grti_div.sv
// Serial restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on grti_pkg only by convention of import.
`timescale 1ns / 1ps
module grti_div
  import grti_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  logic [32:0] rem;
  logic [6:0]  cnt;
  logic        run;
  logic [32:0] trial;

  assign trial = {rem[31:0], quotient[63]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 7'd0;
        rem <= '0;
        quotient <= dividend;
      end else if (run) begin
        if (!trial[32]) begin
          rem <= trial;
          quotient <= {quotient[62:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quotient[63]};
          quotient <= {quotient[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/gyro_rotation_table_interpolator_top.sv
// Gyro rotation table interpolator: integrates gyro rates into a table and
// answers interpolated rotation queries. Clear and no-op: busy stays low.
// Sample: reads the previous entry, multiplies, adds, writes (the first entry or
// a full table goes straight to the write). Query: scans entries, then emits at
// either end, after reading the lower entry on a zero gap, or after one divider
// run per axis when interpolating; at once with fewer than two entries. One item
// at a time. A query's result strobe lasts one cycle, rising as busy falls; the
// receiver cannot stall. Sync reset empties the table, clears overflow, not memory.
`timescale 1ns / 1ps
module gyro_rotation_table_interpolator_top
  import grti_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      strobe,
  output out_item_t out_item
);
  state_t state, state_next;
  in_item_t    req;
  logic [CW-1:0] count;
  logic        ovf;
  logic [AW-1:0] addr;
  logic [AW-1:0] f;
  logic        we;
  entry_t      wdata, rdata;
  entry_t      fe;          // front entry, held during interpolation
  entry_t      prev;
  logic signed [63:0] prod [3];
  logic signed [31:0] res [3];
  logic [1:0]  axis;
  logic [63:0] mag;
  logic        neg;
  logic [31:0] gap, num;
  logic        dgo, ddone;
  logic [63:0] dq;
  logic [31:0] tclamp;
  logic        interp;

  grti_ram u_ram (.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));
  grti_div u_div (.clk(clk), .rst(rst), .go(dgo), .dividend(mag + {32'd0, 1'b0, gap[31:1]}),
                  .divisor(gap), .done(ddone), .quotient(dq));

  assign busy = (state != S_IDLE);

  // saturating add of floor(p / 2^20) (arithmetic shift floors)
  function automatic logic signed [31:0] integ(input logic signed [31:0] a,
                                               input logic signed [63:0] p);
    logic signed [64:0] s;
    begin
      s = 65'(a) + 65'(p >>> 20);
      if (s > 65'sd2147483647) integ = 32'sh7fffffff;
      else if (s < -65'sd2147483648) integ = 32'sh80000000;
      else integ = s[31:0];
    end
  endfunction

  function automatic logic signed [31:0] pick(input entry_t e, input logic [1:0] i);
    begin
      case (i)
        2'd0:    pick = e.ax;
        2'd1:    pick = e.ay;
        default: pick = e.az;
      endcase
    end
  endfunction

  function automatic logic [31:0] tclamp_r(input logic [31:0] pt);
    begin
      tclamp_r = (req.sample_time < pt) ? pt : req.sample_time;
    end
  endfunction

  logic signed [32:0] diff;
  assign diff = 33'(pick(fe, axis)) - 33'(pick(prev, axis));
  assign tclamp = (req.sample_time < prev.t) ? prev.t : req.sample_time;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    addr  = f;
    we    = 1'b0;
    wdata = '0;
    dgo   = 1'b0;
    case (state)
      S_IDLE: if (start) begin
        case (op_t'(in_item.opcode))
          OP_SAMPLE: state_next = S_RDPREV;
          OP_QUERY:  state_next = S_SCAN;
          default:   state_next = S_IDLE;
        endcase
      end
      S_RDPREV: begin
        addr = AW'(count - CW'(1));
        if (count == '0 || count == CW'(TABLE_DEPTH)) state_next = S_WRITE;
        else state_next = S_WAITPREV;
      end
      S_WAITPREV: begin
        // hold the address so the previous entry stays on the read port
        addr = AW'(count - CW'(1));
        state_next = S_MUL;
      end
      S_MUL:      state_next = S_ADD;
      S_ADD:      state_next = S_WRITE;
      S_WRITE: begin
        addr = AW'(count);
        we = (count != CW'(TABLE_DEPTH));
        if (count == '0) wdata = '{t: req.sample_time, ax: '0, ay: '0, az: '0};
        else wdata = '{t: tclamp, ax: res[0], ay: res[1], az: res[2]};
        state_next = S_IDLE;
      end
      S_SCAN: state_next = (count < CW'(2)) ? S_EMIT : S_SCANCHK;
      S_SCANCHK: begin
        if (CW'(f) < count - CW'(1) && req.sample_time >= rdata.t) state_next = S_SCAN;
        else if (req.sample_time > rdata.t || f == '0) state_next = S_EMIT;
        else state_next = S_RDB;
      end
      S_RDB: begin
        addr = f - AW'(1);
        state_next = S_WAITB;
      end
      S_WAITB: begin
        addr = f - AW'(1);
        state_next = S_MULQ;
      end
      S_MULQ: begin
        if (gap == '0) state_next = S_EMIT;
        else state_next = S_DIV;
        dgo = (gap != '0);
      end
      S_DIV: if (ddone) state_next = S_FIN;
      S_FIN: begin
        if (axis == 2'd2) state_next = S_EMIT;
        else state_next = S_MULQ;
      end
      S_EMIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // mag for the axis the divider starts on
  always_comb begin
    logic [32:0] a;
    a = diff[32] ? 33'(-diff) : 33'(diff);
    mag = 64'(a) * 64'(num);
  end
  assign neg = diff[32];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      ovf    <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          req <= in_item;
          f <= '0;
          axis <= 2'd0;
          if (op_t'(in_item.opcode) == OP_CLEAR) begin
            count <= '0;
            ovf <= 1'b0;
          end
        end
        S_MUL: begin
          prev <= rdata;
          prod[0] <= 64'(req.rate_x) * $signed({32'd0, tclamp_r(rdata.t) - rdata.t});
          prod[1] <= 64'(req.rate_y) * $signed({32'd0, tclamp_r(rdata.t) - rdata.t});
          prod[2] <= 64'(req.rate_z) * $signed({32'd0, tclamp_r(rdata.t) - rdata.t});
        end
        S_ADD: begin
          res[0] <= integ(prev.ax, prod[0]);
          res[1] <= integ(prev.ay, prod[1]);
          res[2] <= integ(prev.az, prod[2]);
        end
        S_WRITE: begin
          if (count == CW'(TABLE_DEPTH)) ovf <= 1'b1;
          else count <= count + CW'(1);
        end
        S_SCANCHK: begin
          fe <= rdata;
          if (CW'(f) < count - CW'(1) && req.sample_time >= rdata.t) f <= f + AW'(1);
        end
        S_WAITB: begin
          prev <= rdata;
          gap <= fe.t - rdata.t;
          num <= req.sample_time - rdata.t;
        end
        S_DIV: if (ddone) res[axis] <= neg ? pick(prev, axis) - dq[31:0]
                                           : pick(prev, axis) + dq[31:0];
        S_FIN: if (axis != 2'd2) axis <= axis + 2'd1;
        S_EMIT: begin
          strobe <= 1'b1;
          out_item.overflowed <= ovf;
          out_item.table_ready <= (count >= CW'(2));
          if (count < CW'(2)) begin
            out_item.angle_x <= '0;
            out_item.angle_y <= '0;
            out_item.angle_z <= '0;
          end else if (axis == 2'd2 && gap != '0 && interp) begin
            out_item.angle_x <= res[0];
            out_item.angle_y <= res[1];
            out_item.angle_z <= res[2];
          end else begin
            out_item.angle_x <= fe.ax;
            out_item.angle_y <= fe.ay;
            out_item.angle_z <= fe.az;
          end
        end
        default: ;
      endcase
    end
  end

  // track whether the query went the interpolation route
  always_ff @(posedge clk) begin
    if (rst) interp <= 1'b0;
    else if (state == S_IDLE) interp <= 1'b0;
    else if (state == S_RDB) interp <= 1'b1;
  end
endmodule
